/* design/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg : shared types and constants for the first-fit block allocator
// Request/result payloads, opcode and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int MEM_CELLS = 128;
  localparam int ID_BITS   = 15;
  localparam int ADDR_W    = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
  localparam int CNT_W     = $clog2(MEM_CELLS + 1);

  localparam int ACT_W    = 2;
  localparam int REQ_W    = 8;
  localparam int BID_W    = 16;
  localparam int ST_W     = 2;
  localparam int NEW_ID_W = 15;
  localparam int CFG_W    = 8;

  localparam logic [CFG_W-1:0] MEM_SIZE_RST = 8'd128;

  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEFRAG = 2'd2;

  localparam logic [ST_W-1:0] ST_ALLOC   = 2'd0;
  localparam logic [ST_W-1:0] ST_NULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_ILLEGAL = 2'd2;
  localparam logic [ST_W-1:0] ST_SILENT  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [REQ_W-1:0]        req_size;
    logic signed [BID_W-1:0] block_id;
  } in_req_t;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [NEW_ID_W-1:0] new_id;
  } out_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD,
    S_CHK,
    S_FILL,
    S_CLR,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_K_ZERO,
    WR_W_CELL,
    WR_F_ID
  } wr_sel_t;

  typedef struct packed {
    logic            load_req;
    logic            rd_en;
    logic            inc_k;
    logic            inc_run;
    logic            clr_run;
    logic            load_f;
    logic            inc_f;
    logic            inc_w;
    logic            inc_id;
    logic            set_hit;
    wr_sel_t         wr_sel;
    logic            st_load;
    logic [ST_W-1:0] st_code;
    logic            out_load;
  } ffa_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             want_zero;
    logic             id_full;
    logic             id_pos;
    logic             k_done;
    logic             cell_zero;
    logic             cell_match;
    logic             run_hit;
    logic             w_eq_k;
    logic             f_eq_k;
    logic             hit;
    logic             out_free;
  } ffa_sts_t;

endpackage

/* design/ffa_ctl.sv */
// ----------------------------------------------------------------------------
// ffa_ctl : allocator sequencer
// Walks the cell store one cell per read/check pair and steers the datapath.
// ----------------------------------------------------------------------------
module ffa_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd
);

  ffa_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ffa_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ffa_pkg::S_DISP;
      end
      ffa_pkg::S_DISP: begin
        case (sts.action)
          ffa_pkg::ACT_ALLOC:
            state_nxt = (sts.want_zero || sts.id_full) ? ffa_pkg::S_DONE : ffa_pkg::S_RD;
          ffa_pkg::ACT_ERASE:
            state_nxt = sts.id_pos ? ffa_pkg::S_RD : ffa_pkg::S_DONE;
          ffa_pkg::ACT_DEFRAG:
            state_nxt = ffa_pkg::S_RD;
          default:
            state_nxt = ffa_pkg::S_DONE;
        endcase
      end
      ffa_pkg::S_RD: begin
        state_nxt = sts.k_done ? ffa_pkg::S_DONE : ffa_pkg::S_CHK;
      end
      ffa_pkg::S_CHK: begin
        state_nxt = ffa_pkg::S_RD;
        case (sts.action)
          ffa_pkg::ACT_ALLOC: begin
            if (sts.cell_zero && sts.run_hit) state_nxt = ffa_pkg::S_FILL;
          end
          ffa_pkg::ACT_DEFRAG: begin
            if (!sts.cell_zero && !sts.w_eq_k) state_nxt = ffa_pkg::S_CLR;
          end
          default: ;
        endcase
      end
      ffa_pkg::S_FILL: begin
        if (sts.f_eq_k) state_nxt = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_CLR: begin
        state_nxt = ffa_pkg::S_RD;
      end
      ffa_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = ffa_pkg::S_IDLE;
      end
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.wr_sel = ffa_pkg::WR_NONE;
    case (state_r)
      ffa_pkg::S_IDLE: begin
        cmd.load_req = in_valid;
      end
      ffa_pkg::S_DISP: begin
        case (sts.action)
          ffa_pkg::ACT_ALLOC: begin
            if (sts.want_zero || sts.id_full) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ffa_pkg::ST_NULL;
            end
          end
          ffa_pkg::ACT_ERASE: begin
            if (!sts.id_pos) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ffa_pkg::ST_ILLEGAL;
            end
          end
          ffa_pkg::ACT_DEFRAG: ;
          default: begin
            cmd.st_load = 1'b1;
            cmd.st_code = ffa_pkg::ST_SILENT;
          end
        endcase
      end
      ffa_pkg::S_RD: begin
        if (sts.k_done) begin
          // scan ran off the end of the active cells
          cmd.st_load = 1'b1;
          case (sts.action)
            ffa_pkg::ACT_ALLOC: cmd.st_code = ffa_pkg::ST_NULL;
            ffa_pkg::ACT_ERASE: cmd.st_code = sts.hit ? ffa_pkg::ST_SILENT
                                                      : ffa_pkg::ST_ILLEGAL;
            default:            cmd.st_code = ffa_pkg::ST_SILENT;
          endcase
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ffa_pkg::S_CHK: begin
        case (sts.action)
          ffa_pkg::ACT_ALLOC: begin
            if (!sts.cell_zero) begin
              cmd.clr_run = 1'b1;
              cmd.inc_k   = 1'b1;
            end else if (sts.run_hit) begin
              cmd.inc_id = 1'b1;
              cmd.load_f = 1'b1;
            end else begin
              cmd.inc_run = 1'b1;
              cmd.inc_k   = 1'b1;
            end
          end
          ffa_pkg::ACT_ERASE: begin
            cmd.inc_k = 1'b1;
            if (sts.cell_match) begin
              cmd.wr_sel  = ffa_pkg::WR_K_ZERO;
              cmd.set_hit = 1'b1;
            end
          end
          default: begin
            if (!sts.cell_zero) begin
              cmd.wr_sel = ffa_pkg::WR_W_CELL;
              cmd.inc_w  = 1'b1;
              cmd.inc_k  = sts.w_eq_k;
            end else begin
              cmd.inc_k = 1'b1;
            end
          end
        endcase
      end
      ffa_pkg::S_FILL: begin
        cmd.wr_sel = ffa_pkg::WR_F_ID;
        if (sts.f_eq_k) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ffa_pkg::ST_ALLOC;
        end else begin
          cmd.inc_f = 1'b1;
        end
      end
      ffa_pkg::S_CLR: begin
        cmd.wr_sel = ffa_pkg::WR_K_ZERO;
        cmd.inc_k  = 1'b1;
      end
      ffa_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* design/ffa_dp.sv */
// ----------------------------------------------------------------------------
// ffa_dp : allocator datapath
// Cell store, scan pointers, id counter, size register and result register.
// ----------------------------------------------------------------------------
module ffa_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffa_pkg::in_req_t            in_data,
  input  logic                        cfg_we,
  input  logic [ffa_pkg::CFG_W-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ffa_pkg::out_res_t           out_data,
  input  ffa_pkg::ffa_cmd_t           cmd,
  output ffa_pkg::ffa_sts_t           sts
);

  ffa_pkg::in_req_t                 req_r;
  logic [ffa_pkg::CFG_W-1:0]        mem_size_r;
  logic [ffa_pkg::CNT_W-1:0]        k_r;
  logic [ffa_pkg::CNT_W-1:0]        run_r;
  logic [ffa_pkg::CNT_W-1:0]        w_r;
  logic [ffa_pkg::ADDR_W-1:0]       f_r;
  logic [ffa_pkg::ID_BITS-1:0]      next_id_r;
  logic                             hit_r;
  logic [ffa_pkg::ST_W-1:0]         st_r;
  logic [ffa_pkg::ID_BITS-1:0]      rd_data_r;
  logic                             rd_vld_r;
  logic [ffa_pkg::MEM_CELLS-1:0]    vld_r;
  logic [ffa_pkg::ID_BITS-1:0]      mem [ffa_pkg::MEM_CELLS];
  logic                             out_valid_r;
  ffa_pkg::out_res_t                out_data_r;

  logic [ffa_pkg::CNT_W-1:0]        lim;
  logic [ffa_pkg::ID_BITS-1:0]      cell_q;
  logic                             we;
  logic [ffa_pkg::ADDR_W-1:0]       waddr;
  logic [ffa_pkg::ID_BITS-1:0]      wdata;
  logic                             out_free;

  // cells beyond the built depth do not exist
  assign lim = (32'(mem_size_r) > ffa_pkg::MEM_CELLS) ? ffa_pkg::CNT_W'(ffa_pkg::MEM_CELLS)
                                                      : ffa_pkg::CNT_W'(mem_size_r);

  // a never-written cell reads as free
  assign cell_q   = rd_vld_r ? rd_data_r : '0;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    we    = 1'b0;
    waddr = k_r[ffa_pkg::ADDR_W-1:0];
    wdata = '0;
    case (cmd.wr_sel)
      ffa_pkg::WR_K_ZERO: begin
        we = 1'b1;
      end
      ffa_pkg::WR_W_CELL: begin
        we    = 1'b1;
        waddr = w_r[ffa_pkg::ADDR_W-1:0];
        wdata = cell_q;
      end
      ffa_pkg::WR_F_ID: begin
        we    = 1'b1;
        waddr = f_r;
        wdata = next_id_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_en) rd_data_r <= mem[k_r[ffa_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= vld_r[k_r[ffa_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r  <= ffa_pkg::MEM_SIZE_RST;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mem_size_r <= cfg_data;
      if (cmd.inc_id) next_id_r <= next_id_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
      k_r   <= '0;
      run_r <= '0;
      w_r   <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.inc_k) k_r <= k_r + 1'b1;
      if (cmd.clr_run) run_r <= '0;
      else if (cmd.inc_run) run_r <= run_r + 1'b1;
      if (cmd.inc_w) w_r <= w_r + 1'b1;
      if (cmd.set_hit) hit_r <= 1'b1;
    end
    // run ends at k, so it starts want-1 cells lower
    if (cmd.load_f)
      f_r <= ffa_pkg::ADDR_W'(32'(k_r) + 32'd1 - 32'(req_r.req_size));
    else if (cmd.inc_f)
      f_r <= f_r + 1'b1;
    if (cmd.st_load) st_r <= cmd.st_code;
    if (cmd.out_load) begin
      out_data_r.status <= st_r;
      out_data_r.new_id <= (st_r == ffa_pkg::ST_ALLOC) ? ffa_pkg::NEW_ID_W'(next_id_r) : '0;
    end
  end

  assign sts.action     = req_r.action;
  assign sts.want_zero  = (req_r.req_size == '0);
  assign sts.id_full    = (next_id_r == '1);
  assign sts.id_pos     = !req_r.block_id[ffa_pkg::BID_W-1] && (req_r.block_id != '0);
  assign sts.k_done     = (k_r >= lim);
  assign sts.cell_zero  = (cell_q == '0);
  assign sts.cell_match = (32'(cell_q) == 32'(req_r.block_id[ffa_pkg::BID_W-1:0]));
  assign sts.run_hit    = ((32'(run_r) + 32'd1) == 32'(req_r.req_size));
  assign sts.w_eq_k     = (w_r == k_r);
  assign sts.f_eq_k     = (32'(f_r) == 32'(k_r));
  assign sts.hit        = hit_r;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core : first-fit cell allocator with compaction
// Allocate, erase and defragment requests over a store of owner ids.
// ----------------------------------------------------------------------------
//   channel  | signals                        | direction
//   ---------+--------------------------------+------------------------------
//   in_      | in_valid, in_stall, in_data    | request in, stall back
//   out_     | out_valid, out_stall, out_data | result out, stall back
//   cfg_     | cfg_valid, cfg_ready, cfg_data | mem_size write in
//
// One request at a time. Each active cell takes a read step and a check
// step in the sequencer (single-port cell store). Allocate then writes each
// cell of the granted run in a fill step, and defragment clears the old
// place of each moved cell in a clear step; there are at most 128 active cells.
// Reset is synchronous; per-cell valid bits clear the store at once, no sweep.
// A result held by out_stall delays the finish of the next request only.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ffa_pkg::in_req_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ffa_pkg::out_res_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ffa_pkg::CFG_W-1:0] cfg_data
);

  ffa_pkg::ffa_cmd_t cmd;
  ffa_pkg::ffa_sts_t sts;

  assign cfg_ready = 1'b1;

  ffa_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but sequencer not busy");

  a_new_id_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status == ffa_pkg::ST_ALLOC) == (out_data.new_id != '0)))
    else $error("new_id inconsistent with status");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  a_single_write_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_sel != ffa_pkg::WR_NONE) |-> !cmd.rd_en)
    else $error("cell store read and written in the same step");
`endif

endmodule

/* sim/ffa_result_checker.sv */
// ----------------------------------------------------------------------------
// ffa_result_checker : result checker for the first-fit block allocator
// Watches the request, result and mem_size channels, keeps its own copy of
// the cell store and id counter, predicts one result per request and
// compares each returned result field by field against the oldest one due.
// ----------------------------------------------------------------------------
module ffa_result_checker
  import ffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_req_t            in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_res_t           out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_seen,
  output logic [ID_BITS-1:0] last_id,
  output logic [ID_BITS-1:0] head_owner
);

  logic [ID_BITS-1:0] cell_tag [MEM_CELLS];
  logic [ID_BITS-1:0] issued_id;
  logic [CFG_W-1:0]   active_span;
  out_res_t           due_results [$];

  function automatic int span_cells();
    return (int'(active_span) > MEM_CELLS) ? MEM_CELLS : int'(active_span);
  endfunction

  function automatic out_res_t grant_run(input logic [REQ_W-1:0] want);
    out_res_t res;
    int       lim;
    int       run;
    res.status = ST_NULL;
    res.new_id = '0;
    lim = span_cells();
    run = 0;
    if (want == '0 || issued_id == {ID_BITS{1'b1}}) return res;
    for (int k = 0; k < lim; k++) begin
      if (cell_tag[k] != '0) begin
        run = 0;
      end else begin
        run++;
        if (run == int'(want)) begin
          issued_id++;
          for (int c = k + 1 - int'(want); c <= k; c++) cell_tag[c] = issued_id;
          res.status = ST_ALLOC;
          res.new_id = NEW_ID_W'(issued_id);
          return res;
        end
      end
    end
    return res;
  endfunction

  function automatic out_res_t free_block(input logic signed [BID_W-1:0] bid);
    out_res_t res;
    int       lim;
    logic     hit;
    res.status = ST_ILLEGAL;
    res.new_id = '0;
    lim = span_cells();
    hit = 1'b0;
    // negative or zero ids never own a cell
    if (bid[BID_W-1] || bid == '0) return res;
    for (int k = 0; k < lim; k++) begin
      if (cell_tag[k] == bid[ID_BITS-1:0]) begin
        cell_tag[k] = '0;
        hit = 1'b1;
      end
    end
    if (hit) res.status = ST_SILENT;
    return res;
  endfunction

  function automatic out_res_t compact_cells();
    out_res_t           res;
    int                 lim;
    int                 w;
    logic [ID_BITS-1:0] v;
    res.status = ST_SILENT;
    res.new_id = '0;
    lim = span_cells();
    w = 0;
    for (int k = 0; k < lim; k++) begin
      if (cell_tag[k] != '0) begin
        v = cell_tag[k];
        cell_tag[k] = '0;
        cell_tag[w] = v;
        w++;
      end
    end
    return res;
  endfunction

  function automatic out_res_t allocator_step(input in_req_t r);
    out_res_t res;
    res.status = ST_SILENT;
    res.new_id = '0;
    case (r.action)
      ACT_ALLOC:  res = grant_run(r.req_size);
      ACT_ERASE:  res = free_block(r.block_id);
      ACT_DEFRAG: res = compact_cells();
      default:    ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_res_t got;
    out_res_t due;
    if (!rst_n) begin
      for (int k = 0; k < MEM_CELLS; k++) cell_tag[k] = '0;
      issued_id = '0;
      active_span = MEM_SIZE_RST;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got status=%0d new_id=%0d",
                   $time, got.status, got.new_id);
        end else begin
          due = due_results.pop_front();
          if (got.status !== due.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, due.status,
                     got.status);
          end
          if (got.new_id !== due.new_id) begin
            mismatches++;
            $display("%0t: new_id expected %0d, got %0d", $time, due.new_id,
                     got.new_id);
          end
        end
      end
      if (cfg_valid && cfg_ready) active_span = cfg_data;
      if (in_valid && !in_stall) due_results.push_back(allocator_step(in_data));
    end
    outstanding = due_results.size();
    last_id = issued_id;
    head_owner = cell_tag[0];
  end

endmodule

/* sim/tb_first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core : testbench for the first-fit allocator
// Directed requests for the corner cases, then random allocate/erase/compact
// traffic over several mem_size settings and idle/stall mixes, then a short
// single-cell allocate/erase pass. Results are checked by
// ffa_result_checker.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_core;
  import ffa_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
  localparam int STUCK_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PER_SETTING  = 200;
  localparam int SETTINGS_N   = 9;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_req_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_res_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  int                 mismatches;
  int                 outstanding;
  int                 results_seen;
  logic [ID_BITS-1:0] last_id;
  logic [ID_BITS-1:0] head_owner;

  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               sent = 0;
  logic [CFG_W-1:0] cur_size = MEM_SIZE_RST;
  logic [CFG_W-1:0] size_plan [SETTINGS_N] = '{8'd128, 8'd1, 8'd24, 8'd200, 8'd8,
                                               8'd64, 8'd128, 8'd3, 8'd255};

  first_fit_block_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ffa_result_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .last_id      (last_id),
    .head_owner   (head_owner)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [REQ_W-1:0] sz,
                          input logic signed [BID_W-1:0] bid);
    in_req_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    r.action = act;
    r.req_size = sz;
    r.block_id = bid;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_size = v;
  endtask

  task automatic random_req();
    int                      r;
    int                      lim;
    int                      hi;
    logic [ACT_W-1:0]        act;
    logic [REQ_W-1:0]        sz;
    logic signed [BID_W-1:0] bid;
    lim = (int'(cur_size) > MEM_CELLS) ? MEM_CELLS : int'(cur_size);
    if (lim < 1) lim = 1;
    hi = int'(last_id);
    sz = REQ_W'($urandom_range(255));
    bid = BID_W'($urandom);
    r = $urandom_range(99);
    if (r < 45) begin
      act = ACT_ALLOC;
      r = $urandom_range(99);
      if (r < 70) sz = REQ_W'($urandom_range((lim + 3) / 4, 1));
      else if (r < 92) sz = REQ_W'($urandom_range(lim, 1));
      else if (r < 97) sz = REQ_W'($urandom_range(255, 129));
      else sz = '0;
    end else if (r < 82) begin
      act = ACT_ERASE;
      r = $urandom_range(99);
      // mostly recent ids, which are the likeliest to still own cells
      if (r < 75 && hi > 0) bid = BID_W'(hi - int'($urandom_range(hi > 25 ? 24 : hi - 1)));
      else if (r < 90) bid = BID_W'($urandom_range(hi + 4, 1));
    end else if (r < 96) begin
      act = ACT_DEFRAG;
    end else begin
      act = ACT_NOP;
    end
    send_req(act, sz, bid);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners at reset size
    send_req(ACT_ALLOC, 8'd0, 16'sd0);
    send_req(ACT_ERASE, 8'd1, 16'sd0);
    send_req(ACT_ERASE, 8'd1, 16'sh8000);
    send_req(ACT_ERASE, 8'd1, 16'sd5);
    send_req(ACT_ALLOC, 8'd128, 16'sd0);
    send_req(ACT_ALLOC, 8'd1, 16'sd0);
    send_req(ACT_ERASE, 8'd0, 16'sd1);
    send_req(ACT_ALLOC, 8'd3, 16'sd0);
    send_req(ACT_ALLOC, 8'd5, 16'sd0);
    send_req(ACT_ALLOC, 8'd2, 16'sd0);
    send_req(ACT_ERASE, 8'd0, 16'sd3);
    send_req(ACT_DEFRAG, 8'd0, 16'sd0);
    send_req(ACT_ALLOC, 8'd255, 16'sd0);
    send_req(ACT_NOP, 8'hff, 16'sh7fff);
    send_req(ACT_ERASE, 8'd0, 16'sh7fff);
    send_req(ACT_ALLOC, 8'd123, 16'sd0);
    // no cells in use
    write_size(8'd0);
    send_req(ACT_ALLOC, 8'd1, 16'sd0);
    send_req(ACT_ERASE, 8'd0, 16'sd2);
    send_req(ACT_DEFRAG, 8'd0, 16'sd0);
    // above the built depth acts as full depth
    write_size(8'd255);
    send_req(ACT_ALLOC, 8'd1, 16'sd0);
    send_req(ACT_ERASE, 8'd0, 16'sd5);
    // one cell: block 2 keeps its cells beyond the span
    write_size(8'd1);
    send_req(ACT_ERASE, 8'd0, 16'sd2);
    send_req(ACT_ALLOC, 8'd1, 16'sd0);

    for (int p = 0; p < SETTINGS_N; p++) begin
      write_size(size_plan[p]);
      if (p < 3) begin
        send_idle_pct = 22;
        stall_pct = 72;
      end else if (p < 6) begin
        send_idle_pct = 72;
        stall_pct = 22;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      repeat (PER_SETTING) begin
        if ($urandom_range(59) == 0) wait_drained();
        random_req();
      end
    end

    // single cell: free it, refill it, overflow it, free it again
    write_size(8'd1);
    if (head_owner != '0) send_req(ACT_ERASE, 8'd0, BID_W'(head_owner));
    send_req(ACT_ALLOC, 8'd1, 16'sd0);
    send_req(ACT_ALLOC, 8'd1, 16'sd0);
    send_req(ACT_ERASE, 8'd0, BID_W'(last_id));
    send_req(ACT_ALLOC, 8'd0, 16'sd0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d requests: corner cases, mem_size 0/1/3/8/24/64/128/200/255,", sent);
    $display("three idle/stall mixes and a single-cell pass up to id %0d; %0d results checked",
             last_id, results_seen);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
design/ffa_pkg.sv
design/ffa_ctl.sv
design/ffa_dp.sv
design/first_fit_block_allocator_core.sv
sim/ffa_result_checker.sv
sim/tb_first_fit_block_allocator_core.sv
